// File: design/sine_cosine_poly_unit_defines.svh
// Assertion macros shared by the sine/cosine polynomial unit RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef SINE_COSINE_POLY_UNIT_DEFINES_SVH
`define SINE_COSINE_POLY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SCP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SCP_ASSERT(label, prop, msg)
`define SCP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: design/scp_pkg.sv
// Package for the sine/cosine polynomial unit: fixed-point constants,
// polynomial coefficients and the stage structs between modules. No dependencies.
package scp_pkg;

   localparam int SCP_ANGLE_FRAC_BITS = 24;
   localparam int SCP_OUT_FRAC_BITS   = 30;

   localparam int SCP_Y_W = 31;

   localparam logic signed [63:0] SCP_Q32_PI      = 64'sd13493037705;
   localparam logic signed [63:0] SCP_Q32_TWO_PI  = 64'sd26986075409;
   localparam logic signed [63:0] SCP_Q32_HALF_PI = 64'sd6746518852;

   // Horner coefficients in Q.30, highest order first, with a trailing zero.
   localparam logic signed [31:0] SCP_COEF [0:4] = '{
      32'sd30830349,
      -32'sd218598803,
      32'sd21425444,
      32'sd1069787233,
      32'sd0
   };

   typedef struct packed {
      logic                 valid;
      logic                 neg;
      logic [SCP_Y_W-1:0]   y;
   } scp_fold_type;

   typedef struct packed {
      logic                 valid;
      logic                 neg;
      logic signed [31:0]   mag;
   } scp_poly_type;

endpackage

// File: design/sine_cosine_poly_unit.sv
// Sine/cosine polynomial unit. Takes one word per cycle while not stalled (an angle in
// radians with ANGLE_FRAC_BITS fraction bits and a sine or cosine request) and returns
// one word per input, the saturated result with OUT_FRAC_BITS fraction bits. The unit is
// a single pipeline: one stage forms the offset angle, 31 - ANGLE_FRAC_BITS stages each
// remove a power-of-two multiple of 2pi by a compare and subtract, three stages take the
// sign, fold and round the angle, one registers the folded angle, eight stages run the
// four Horner steps (multiply, then round and add), one rounds to the output format and
// the output register applies sign and saturation. A stalled result freezes the whole
// pipeline; req_stall is high exactly while rsp_valid and rsp_stall are.
// Depends on scp_pkg, scp_reduce, scp_horner and the defines header.
`include "sine_cosine_poly_unit_defines.svh"

module sine_cosine_poly_unit #(
   parameter int ANGLE_FRAC_BITS = scp_pkg::SCP_ANGLE_FRAC_BITS,
   parameter int OUT_FRAC_BITS   = scp_pkg::SCP_OUT_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic signed [31:0]  req_angle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_value
);
   import scp_pkg::*;

   localparam logic signed [31:0] VAL_MAX   = 32'sh7fffffff;
   localparam logic signed [31:0] VAL_MIN   = 32'sh80000000;
   localparam logic signed [31:0] VAL_LIMIT =
      (32'sd1 <<< OUT_FRAC_BITS) + (32'sd1 <<< (OUT_FRAC_BITS - 6));

   logic               advance;
   scp_fold_type       fold;
   scp_poly_type       poly;
   logic signed [32:0] mag_x;
   logic signed [32:0] val_x;
   logic signed [31:0] rsp_value_in, rsp_value_ff;
   logic               rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   scp_reduce #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_angle (req_angle),
      .fold      (fold)
   );

   scp_horner #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_horner (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .fold    (fold),
      .poly    (poly)
   );

   always_comb begin
      mag_x = {poly.mag[31], poly.mag};
      val_x = poly.neg ? -mag_x : mag_x;
      if (val_x[32] != val_x[31]) begin
         rsp_value_in = val_x[32] ? VAL_MIN : VAL_MAX;
      end else begin
         rsp_value_in = val_x[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= poly.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   `SCP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")
   `SCP_ASSERT(a_stall_holds, req_stall |=> $stable(poly), "pipeline moved while stalled")
   `SCP_ASSERT(a_value_bound,
      rsp_valid |-> (rsp_value <= VAL_LIMIT) && (rsp_value >= -VAL_LIMIT),
      "result beyond unit magnitude")

endmodule

// File: design/scp_reduce.sv
// Range reduction for the sine/cosine unit: angle to Q.32, mod 2pi, fold to [0, pi/2].
// Depends on scp_pkg and sine_cosine_poly_unit_defines.svh.
`include "sine_cosine_poly_unit_defines.svh"

module scp_reduce #(
   parameter int ANGLE_FRAC_BITS = scp_pkg::SCP_ANGLE_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 req_valid,
   input  logic                 req_type,
   input  logic signed [31:0]   req_angle,
   output scp_pkg::scp_fold_type fold
);
   import scp_pkg::*;

   localparam int SHIFT = 32 - ANGLE_FRAC_BITS;
   localparam int K     = SHIFT - 2;
   localparam int NSTEP = SHIFT - 1;
   localparam int UW    = 34 + SHIFT;
   localparam int SW    = UW + 1;

   localparam logic signed [SW-1:0] SIN_BASE =
      SW'(SCP_Q32_PI) + (SW'(SCP_Q32_TWO_PI) <<< K);
   localparam logic signed [SW-1:0] COS_BASE = SIN_BASE + SW'(SCP_Q32_HALF_PI);
   localparam logic [UW-1:0] TWO_PI_U = UW'(SCP_Q32_TWO_PI);
   localparam logic [34:0]   PI_F     = 35'(SCP_Q32_PI);
   localparam logic [33:0]   PI_M     = 34'(SCP_Q32_PI);
   localparam logic [33:0]   HALF_M   = 34'(SCP_Q32_HALF_PI);
   localparam logic [SCP_Y_W-1:0] Y_MAX = SCP_Y_W'((SCP_Q32_HALF_PI + 64'sd2) >>> 2);

   logic signed [SW-1:0] x_ext;
   logic signed [SW-1:0] t_sum;
   logic [UW-1:0]        u_in;
   logic [UW-1:0]        u_ff    [0:NSTEP];
   logic [UW-1:0]        step_in [0:NSTEP-1];
   logic [NSTEP:0]       vld_ff;

   logic [34:0]          f_val;
   logic                 neg_in, neg_ff;
   logic [33:0]          mag_in, mag_ff;
   logic                 sgn_vld_ff;

   logic [32:0]          fold_in, fold_mag_ff;
   logic                 fold_neg_ff, fold_vld_ff;

   logic [33:0]          y_sum;
   logic [SCP_Y_W-1:0]   y_in, y_ff;
   logic                 y_neg_ff, y_vld_ff;

   always_comb begin
      x_ext = SW'(req_angle) <<< SHIFT;
      t_sum = req_type ? (COS_BASE - x_ext) : (SIN_BASE + x_ext);
      u_in  = t_sum[UW-1:0];
      for (int j = 0; j < NSTEP; j++) begin
         step_in[j] = (u_ff[j] >= (TWO_PI_U << (K - j))) ?
                      (u_ff[j] - (TWO_PI_U << (K - j))) : u_ff[j];
      end
      f_val   = u_ff[NSTEP][34:0];
      neg_in  = f_val < PI_F;
      mag_in  = neg_in ? 34'(PI_F - f_val) : 34'(f_val - PI_F);
      fold_in = (mag_ff >= HALF_M) ? 33'(PI_M - mag_ff) : mag_ff[32:0];
      y_sum   = {1'b0, fold_mag_ff} + 34'd2;
      y_in    = y_sum[32:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         sgn_vld_ff  <= 1'b0;
         fold_vld_ff <= 1'b0;
         y_vld_ff    <= 1'b0;
      end else if (advance) begin
         vld_ff      <= {vld_ff[NSTEP-1:0], req_valid};
         sgn_vld_ff  <= vld_ff[NSTEP];
         fold_vld_ff <= sgn_vld_ff;
         y_vld_ff    <= fold_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u_ff[0] <= u_in;
         for (int j = 0; j < NSTEP; j++) begin
            u_ff[j+1] <= step_in[j];
         end
         neg_ff      <= neg_in;
         mag_ff      <= mag_in;
         fold_neg_ff <= neg_ff;
         fold_mag_ff <= fold_in;
         y_neg_ff    <= fold_neg_ff;
         y_ff        <= y_in;
      end
   end

   assign fold = '{valid: y_vld_ff, neg: y_neg_ff, y: y_ff};

   // The folded value never exceeds pi/2 rounded to Q.30.
   `SCP_ASSERT(a_fold_bound, y_vld_ff |-> (y_ff <= Y_MAX), "folded angle out of range")

endmodule

// File: design/scp_horner.sv
// Quartic Horner evaluation in Q.30 with a multiply stage and a round stage per step,
// then rounding to the output format. Depends on scp_pkg and the defines header.
`include "sine_cosine_poly_unit_defines.svh"

module scp_horner #(
   parameter int OUT_FRAC_BITS = scp_pkg::SCP_OUT_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  scp_pkg::scp_fold_type fold,
   output scp_pkg::scp_poly_type poly
);
   import scp_pkg::*;

   localparam int SH = 30 - OUT_FRAC_BITS;
   localparam logic [32:0] RND_HALF = (33'd1 << SH) >> 1;
   localparam logic [32:0] RND_NEG  = (SH == 0) ? 33'd0 : (RND_HALF - 33'd1);

   logic [3:0]               mul_vld_ff, mul_neg_ff;
   logic [SCP_Y_W-1:0]       mul_y_ff  [0:3];
   logic signed [63:0]       prod_ff   [0:3];
   logic signed [63:0]       prod_in   [0:3];
   logic signed [31:0]       opnd      [0:3];
   logic [SCP_Y_W-1:0]       y_src     [0:3];

   logic [3:0]               rnd_vld_ff, rnd_neg_ff;
   logic [SCP_Y_W-1:0]       rnd_y_ff  [0:3];
   logic signed [31:0]       acc_ff    [0:3];
   logic signed [31:0]       acc_in    [0:3];
   logic                     acc_vld_ff, acc_neg_ff;

   logic [32:0]              fin_sum;
   logic signed [32:0]       fin_shift;
   logic signed [31:0]       fin_in, fin_mag_ff;
   logic                     fin_vld_ff, fin_neg_ff;

   function automatic logic signed [31:0] scp_rnd30(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + (p[63] ? 64'sd536870911 : 64'sd536870912);
      return s[61:30];
   endfunction

   always_comb begin
      opnd[0]  = SCP_COEF[0];
      y_src[0] = fold.y;
      for (int i = 1; i < 4; i++) begin
         opnd[i]  = acc_ff[i-1];
         y_src[i] = rnd_y_ff[i-1];
      end
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = signed'({1'b0, mul_y_ff[i]}) * opnd[i];
         acc_in[i]  = scp_rnd30(prod_ff[i]) + SCP_COEF[i+1];
      end
      fin_sum   = {acc_ff[3][31], acc_ff[3]} + (acc_ff[3][31] ? RND_NEG : RND_HALF);
      fin_shift = signed'(fin_sum) >>> SH;
      fin_in    = fin_shift[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= '0;
         rnd_vld_ff <= '0;
         acc_vld_ff <= 1'b0;
         fin_vld_ff <= 1'b0;
      end else if (advance) begin
         mul_vld_ff <= {rnd_vld_ff[2:0], fold.valid};
         rnd_vld_ff <= mul_vld_ff;
         acc_vld_ff <= rnd_vld_ff[3];
         fin_vld_ff <= acc_vld_ff;
      end
   end

   // The multiplier operand of step 0 is a constant, so its product stage takes y only.
   always_ff @(posedge clock) begin
      if (advance) begin
         mul_neg_ff <= {rnd_neg_ff[2:0], fold.neg};
         rnd_neg_ff <= mul_neg_ff;
         for (int i = 0; i < 4; i++) begin
            mul_y_ff[i] <= y_src[i];
            prod_ff[i]  <= prod_in[i];
            rnd_y_ff[i] <= mul_y_ff[i];
            acc_ff[i]   <= acc_in[i];
         end
         acc_neg_ff <= rnd_neg_ff[3];
         fin_neg_ff <= acc_neg_ff;
         fin_mag_ff <= fin_in;
      end
   end

   assign poly = '{valid: fin_vld_ff, neg: fin_neg_ff, mag: fin_mag_ff};

   // On [0, pi/2] the polynomial is never negative.
   `SCP_ASSERT(a_poly_nonneg, acc_vld_ff |-> !acc_ff[3][31], "negative polynomial value")

endmodule
